@@ src/sdfcs_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI DataFlash command sequencer package
// Job kinds, the job and frame records passed between the front end, the
// job queue and the frame generator, and the frame lookup functions.
// ----------------------------------------------------------------------------
package sdfcs_pkg;

    // Frame-list kinds carried by a queued job.
    localparam logic [3:0] K_ADDR_POLL   = 4'd0;  // four address bytes, then a status poll
    localparam logic [3:0] K_ADDR_DONE   = 4'd1;  // four address bytes, done on the last
    localparam logic [3:0] K_WRITE       = 4'd2;  // buffer byte write, five bytes
    localparam logic [3:0] K_READ        = 4'd3;  // buffer byte read, six bytes
    localparam logic [3:0] K_POLL        = 4'd4;  // status opcode and dummy byte
    localparam logic [3:0] K_ID_START    = 4'd5;  // ID opcode and first dummy byte
    localparam logic [3:0] K_NOTICE_DONE = 4'd6;  // completion notice
    localparam logic [3:0] K_NOTICE_DATA = 4'd7;  // returned data notice
    localparam logic [3:0] K_ID_MID      = 4'd8;  // ID byte, ask for another
    localparam logic [3:0] K_ID_END      = 4'd9;  // last ID byte

    // Flash opcodes and fixed bytes.
    localparam logic [7:0] OPC_PAGE_ERASE = 8'h81;
    localparam logic [7:0] OPC_CHIP_ERASE = 8'hC7;
    localparam logic [7:0] OPC_CHIP_2     = 8'h94;
    localparam logic [7:0] OPC_CHIP_3     = 8'h80;
    localparam logic [7:0] OPC_CHIP_4     = 8'h9A;
    localparam logic [7:0] OPC_TO_BUF1    = 8'h53;
    localparam logic [7:0] OPC_TO_BUF2    = 8'h55;
    localparam logic [7:0] OPC_TO_PAGE1   = 8'h83;
    localparam logic [7:0] OPC_TO_PAGE2   = 8'h86;
    localparam logic [7:0] OPC_WRITE1     = 8'h84;
    localparam logic [7:0] OPC_WRITE2     = 8'h87;
    localparam logic [7:0] OPC_READ1      = 8'hD4;
    localparam logic [7:0] OPC_READ2      = 8'hD6;
    localparam logic [7:0] OPC_STATUS     = 8'hD7;
    localparam logic [7:0] OPC_ID         = 8'h9F;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] BYTE_ONES      = 8'hFF;

    // Input command codes.
    localparam logic [3:0] OP_PAGE_ERASE = 4'd0;
    localparam logic [3:0] OP_CHIP_ERASE = 4'd1;
    localparam logic [3:0] OP_TO_BUF     = 4'd2;
    localparam logic [3:0] OP_TO_PAGE    = 4'd3;
    localparam logic [3:0] OP_WRITE      = 4'd4;
    localparam logic [3:0] OP_READ       = 4'd5;
    localparam logic [3:0] OP_STATUS     = 4'd6;
    localparam logic [3:0] OP_ID         = 4'd7;
    localparam logic [3:0] OP_REPLY      = 4'd8;

    typedef struct packed {
        logic [3:0]      kind;
        logic [4:0][7:0] bytes;   // command bytes, or the returned byte in entry 0
    } t_job;

    typedef struct packed {
        logic       done_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       want_reply;
        logic       release_select;
        logic [7:0] mosi_byte;
    } t_frame;

    // Number of frames a job produces.
    function automatic logic [2:0] job_len(input logic [3:0] kind);
        logic [2:0] len;
        case (kind)
            K_ADDR_POLL:   len = 3'd6;
            K_ADDR_DONE:   len = 3'd4;
            K_WRITE:       len = 3'd5;
            K_READ:        len = 3'd6;
            K_POLL:        len = 3'd2;
            K_ID_START:    len = 3'd2;
            default:       len = 3'd1;
        endcase
        return len;
    endfunction

    // Frame number idx of a job.
    function automatic t_frame job_frame(input t_job job, input logic [2:0] idx);
        t_frame f;
        logic [7:0] b;
        f = '0;
        b = (idx <= 3'd4) ? job.bytes[idx] : BYTE_ZERO;
        case (job.kind)
            K_ADDR_POLL: begin
                if (idx <= 3'd3) begin
                    f.mosi_byte      = b;
                    f.release_select = (idx == 3'd3);
                end else if (idx == 3'd4) begin
                    f.mosi_byte = OPC_STATUS;
                end else begin
                    f.release_select = 1'b1;
                    f.want_reply     = 1'b1;
                end
            end
            K_ADDR_DONE: begin
                f.mosi_byte      = b;
                f.release_select = (idx == 3'd3);
                f.done_res       = (idx == 3'd3);
            end
            K_WRITE: begin
                f.mosi_byte      = b;
                f.release_select = (idx == 3'd4);
                f.done_res       = (idx == 3'd4);
            end
            K_READ: begin
                f.mosi_byte      = (idx <= 3'd3) ? b : BYTE_ZERO;
                f.release_select = (idx == 3'd5);
                f.want_reply     = (idx == 3'd5);
            end
            K_POLL: begin
                f.mosi_byte      = (idx == 3'd0) ? OPC_STATUS : BYTE_ZERO;
                f.release_select = (idx == 3'd1);
                f.want_reply     = (idx == 3'd1);
            end
            K_ID_START: begin
                f.mosi_byte  = (idx == 3'd0) ? OPC_ID : BYTE_ONES;
                f.want_reply = (idx == 3'd1);
            end
            K_NOTICE_DONE: begin
                f.done_res = 1'b1;
            end
            K_NOTICE_DATA: begin
                f.read_byte  = job.bytes[0];
                f.read_valid = 1'b1;
                f.done_res   = 1'b1;
            end
            K_ID_MID: begin
                f.mosi_byte  = BYTE_ONES;
                f.want_reply = 1'b1;
                f.read_byte  = job.bytes[0];
                f.read_valid = 1'b1;
            end
            K_ID_END: begin
                f.mosi_byte      = BYTE_ONES;
                f.release_select = 1'b1;
                f.read_byte      = job.bytes[0];
                f.read_valid     = 1'b1;
                f.done_res       = 1'b1;
            end
            default: begin
                f = '0;
            end
        endcase
        return f;
    endfunction

endpackage

@@ src/sdfcs_front.sv @@
// ----------------------------------------------------------------------------
// SPI DataFlash command front end
// Accepts command and reply items, tracks the command phase, reduces the page
// number and hands one job per productive item to the job queue.
// ----------------------------------------------------------------------------
module sdfcs_front
    import sdfcs_pkg::*;
#(
    parameter int PAGE_COUNT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_op,
    input  logic        i_buffer_select,
    input  logic [11:0] i_page_number,
    input  logic [9:0]  i_byte_offset,
    input  logic [7:0]  i_write_byte,
    input  logic        i_wait_ready,
    input  logic [7:0]  i_reply_byte,
    input  logic        i_page_size_is_512,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_job        o_job
);

    // Phase codes.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_POLL   = 3'd1;
    localparam logic [2:0] PH_STATUS = 3'd2;
    localparam logic [2:0] PH_READ   = 3'd3;
    localparam logic [2:0] PH_ID     = 3'd4;

    // Reciprocal for the page modulo: exact quotient for any 12-bit page.
    localparam int MOD_SHIFT = 24;
    localparam int MOD_RECIP = ((1 << MOD_SHIFT) + PAGE_COUNT - 1) / PAGE_COUNT;

    logic [2:0]  r_phase;
    logic [1:0]  r_id_seen;
    logic        r_s1_valid;
    t_job        r_s1_job;
    logic        r_s1_use_page;
    logic [11:0] r_s1_page;
    logic [11:0] r_s1_quot;

    logic [2:0]  n_phase;
    logic [1:0]  n_id_seen;
    logic        n_s1_valid;
    t_job        n_s1_job;
    logic        n_s1_use_page;
    logic [35:0] quot_prod;
    logic        accept;
    logic        advance;

    assign advance = r_s1_valid && !i_queue_full;
    assign o_ready = !r_s1_valid || !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign quot_prod = 36'(i_page_number) * 36'(MOD_RECIP);

    // Classify the item and step the phase.
    always_comb begin
        n_phase       = r_phase;
        n_id_seen     = r_id_seen;
        n_s1_valid    = 1'b0;
        n_s1_use_page = 1'b0;
        n_s1_job      = '0;
        if (i_op == OP_REPLY) begin
            n_s1_job.bytes[0] = i_reply_byte;
            case (r_phase)
                PH_POLL: begin
                    n_s1_valid = 1'b1;
                    if (i_reply_byte[7]) begin
                        n_s1_job.kind = K_NOTICE_DONE;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_s1_job.kind = K_POLL;
                    end
                end
                PH_STATUS, PH_READ: begin
                    n_s1_valid    = 1'b1;
                    n_s1_job.kind = K_NOTICE_DATA;
                    n_phase       = PH_IDLE;
                end
                PH_ID: begin
                    n_s1_valid = 1'b1;
                    if (r_id_seen < 2'd2) begin
                        n_s1_job.kind = K_ID_MID;
                        n_id_seen     = r_id_seen + 2'd1;
                    end else begin
                        n_s1_job.kind = K_ID_END;
                        n_id_seen     = 2'd0;
                        n_phase       = PH_IDLE;
                    end
                end
                default: begin
                    n_s1_valid = 1'b0;
                end
            endcase
        end else if (r_phase == PH_IDLE && i_op <= OP_ID) begin
            n_s1_valid = 1'b1;
            case (i_op)
                OP_PAGE_ERASE: begin
                    n_s1_job.kind     = K_ADDR_POLL;
                    n_s1_job.bytes[0] = OPC_PAGE_ERASE;
                    n_s1_use_page     = 1'b1;
                    n_phase           = PH_POLL;
                end
                OP_CHIP_ERASE: begin
                    n_s1_job.kind     = K_ADDR_POLL;
                    n_s1_job.bytes[0] = OPC_CHIP_ERASE;
                    n_s1_job.bytes[1] = OPC_CHIP_2;
                    n_s1_job.bytes[2] = OPC_CHIP_3;
                    n_s1_job.bytes[3] = OPC_CHIP_4;
                    n_phase           = PH_POLL;
                end
                OP_TO_BUF: begin
                    n_s1_job.kind     = K_ADDR_POLL;
                    n_s1_job.bytes[0] = i_buffer_select ? OPC_TO_BUF2 : OPC_TO_BUF1;
                    n_s1_use_page     = 1'b1;
                    n_phase           = PH_POLL;
                end
                OP_TO_PAGE: begin
                    n_s1_job.kind     = i_wait_ready ? K_ADDR_POLL : K_ADDR_DONE;
                    n_s1_job.bytes[0] = i_buffer_select ? OPC_TO_PAGE2 : OPC_TO_PAGE1;
                    n_s1_use_page     = 1'b1;
                    n_phase           = i_wait_ready ? PH_POLL : PH_IDLE;
                end
                OP_WRITE: begin
                    n_s1_job.kind     = K_WRITE;
                    n_s1_job.bytes[0] = i_buffer_select ? OPC_WRITE2 : OPC_WRITE1;
                    n_s1_job.bytes[2] = {6'd0, i_byte_offset[9:8]};
                    n_s1_job.bytes[3] = i_byte_offset[7:0];
                    n_s1_job.bytes[4] = i_write_byte;
                end
                OP_READ: begin
                    n_s1_job.kind     = K_READ;
                    n_s1_job.bytes[0] = i_buffer_select ? OPC_READ2 : OPC_READ1;
                    n_s1_job.bytes[2] = {6'd0, i_byte_offset[9:8]};
                    n_s1_job.bytes[3] = i_byte_offset[7:0];
                    n_phase           = PH_READ;
                end
                OP_STATUS: begin
                    n_s1_job.kind = K_POLL;
                    n_phase       = PH_STATUS;
                end
                default: begin
                    n_s1_job.kind = K_ID_START;
                    n_id_seen     = 2'd0;
                    n_phase       = PH_ID;
                end
            endcase
        end
    end

    // Phase state and the first stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_id_seen  <= 2'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_id_seen  <= n_id_seen;
                r_s1_valid <= n_s1_valid;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_job      <= n_s1_job;
            r_s1_use_page <= n_s1_use_page;
            r_s1_page     <= i_page_number;
            r_s1_quot     <= quot_prod[MOD_SHIFT +: 12];
        end
    end

    // Second stage: page remainder and address packing.
    logic [23:0] quot_times;
    logic [11:0] rem_raw;
    logic [11:0] page_mod;

    assign quot_times = 24'(r_s1_quot) * 24'(PAGE_COUNT);
    assign rem_raw    = r_s1_page - quot_times[11:0];
    assign page_mod   = ({1'b0, rem_raw} >= 13'(PAGE_COUNT))
                        ? 12'(rem_raw - 12'(PAGE_COUNT)) : rem_raw;

    always_comb begin
        o_job = r_s1_job;
        if (r_s1_use_page) begin
            if (i_page_size_is_512) begin
                o_job.bytes[1] = {3'd0, page_mod[11:7]};
                o_job.bytes[2] = {page_mod[6:0], 1'b0};
            end else begin
                o_job.bytes[1] = {2'd0, page_mod[11:6]};
                o_job.bytes[2] = {page_mod[5:0], 2'b00};
            end
            o_job.bytes[3] = BYTE_ZERO;
        end
    end

    assign o_push = advance;

endmodule

@@ src/sdfcs_queue.sv @@
// ----------------------------------------------------------------------------
// SPI DataFlash job queue
// Two-entry queue of jobs between the front end and the frame generator.
// ----------------------------------------------------------------------------
module sdfcs_queue
    import sdfcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_entry[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ src/sdfcs_back.sv @@
// ----------------------------------------------------------------------------
// SPI DataFlash frame generator
// Walks the frame list of the job at the queue head and loads one frame per
// cycle into the output register while that register is free or being taken.
// ----------------------------------------------------------------------------
module sdfcs_back
    import sdfcs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_job   i_head,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_frame o_frame,
    output logic   o_last
);

    logic [2:0] r_idx;
    logic       r_out_valid;
    t_frame     r_out_frame;
    logic       r_out_last;

    logic       load;
    logic       is_last;

    assign load    = !i_empty && (!r_out_valid || i_ready);
    assign is_last = (r_idx == job_len(i_head.kind) - 3'd1);
    assign o_pop   = load && is_last;

    // Frame counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= is_last ? 3'd0 : r_idx + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_frame <= job_frame(i_head, r_idx);
            r_out_last  <= is_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_frame = r_out_frame;
    assign o_last  = r_out_last;

endmodule

@@ src/spi_dataflash_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// SPI DataFlash command sequencer
// Turns flash commands into SPI byte frames and MISO replies into data and
// completion notices, with status polling after erase and transfer commands.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: op; tdata: command fields and reply byte
//   m_axis    out        tdata: one SPI frame or notice; tlast: last of item
//   APB       in/out     page_size_is_512 at address 0
//
// Input items are accepted back to back while the two-entry job queue has
// room; an item passes through the first stage register, a queue entry and
// the output register on its way out. The frame generator sends one frame
// per cycle while m_axis takes frames, so a command gives one to six frames.
// Reset is synchronous and needs no clearing pass. Either side may stall
// freely; the output register decouples the frame generator from m_axis.
// ----------------------------------------------------------------------------
module spi_dataflash_command_sequencer
    import sdfcs_pkg::*;
#(
    parameter int PAGE_COUNT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] op
    input  logic [3:0]  s_axis_tuser,
    // [0] buffer_select, [12:1] page_number, [22:13] byte_offset,
    // [30:23] write_byte, [31] wait_ready, [39:32] reply_byte
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] mosi_byte, [8] release_select, [9] want_reply, [17:10] read_byte,
    // [18] read_valid, [19] done_res, [23:20] zero
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic   r_page_size_is_512;
    logic   push;
    t_job   push_job;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;
    t_job   head_job;
    t_frame out_frame;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_page_size_is_512} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size_is_512 <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_page_size_is_512 <= pwdata[0];
        end
    end

    sdfcs_front #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (s_axis_tvalid),
        .o_ready            (s_axis_tready),
        .i_op               (s_axis_tuser),
        .i_buffer_select    (s_axis_tdata[0]),
        .i_page_number      (s_axis_tdata[12:1]),
        .i_byte_offset      (s_axis_tdata[22:13]),
        .i_write_byte       (s_axis_tdata[30:23]),
        .i_wait_ready       (s_axis_tdata[31]),
        .i_reply_byte       (s_axis_tdata[39:32]),
        .i_page_size_is_512 (r_page_size_is_512),
        .i_queue_full       (queue_full),
        .o_push             (push),
        .o_job              (push_job)
    );

    sdfcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head_job)
    );

    sdfcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (queue_empty),
        .i_head  (head_job),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_frame (out_frame),
        .o_last  (m_axis_tlast)
    );

    // Output packing.
    assign m_axis_tdata = {4'd0, out_frame.done_res, out_frame.read_valid,
                           out_frame.read_byte, out_frame.want_reply,
                           out_frame.release_select, out_frame.mosi_byte};

endmodule

@@ sim/tb_spi_dataflash_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// Testbench for the SPI DataFlash command sequencer
// Sends flash commands and MISO replies on the input stream and works out
// the SPI frames and notices each accepted item must produce. Every frame
// taken from the output stream is checked field by field against the oldest
// frame still due. Both page address packings are set over the APB port and
// read back. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_spi_dataflash_command_sequencer;
    import sdfcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PAGE_COUNT     = 4096;
    localparam int         RANDOM_ITEMS   = 426;
    localparam int         SETTLE_CYCLES  = 12;
    localparam logic [2:0] ADDR_PAGE_SIZE = 3'd0;

    // Where the sequencer stands between items.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_POLL,
        SEQ_STATUS,
        SEQ_READ,
        SEQ_ID
    } t_seq_phase;

    // One SPI frame or notice as seen on the output stream.
    typedef struct {
        logic [7:0] mosi_byte;
        logic       release_select;
        logic       want_reply;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic       last;
    } t_spi_frame;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    // [3:0] op
    logic [3:0]  s_axis_tuser   = '0;
    // [0] buffer_select, [12:1] page_number, [22:13] byte_offset,
    // [30:23] write_byte, [31] wait_ready, [39:32] reply_byte
    logic [39:0] s_axis_tdata   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    // [7:0] mosi_byte, [8] release_select, [9] want_reply, [17:10] read_byte,
    // [18] read_valid, [19] done_res, [23:20] zero
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state and scoreboard.
    t_spi_frame  frames_due[$];
    t_seq_phase  seq_phase      = SEQ_IDLE;
    logic [1:0]  id_bytes_taken = '0;
    logic        pack_512       = 1'b0;
    logic        calm           = 1'b0;
    int          error_count    = 0;
    int          items_acted    = 0;
    int          items_ignored  = 0;
    int          frames_checked = 0;

    spi_dataflash_command_sequencer #(
        .PAGE_COUNT(PAGE_COUNT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // Run limit, far above the slowest correct run.
    initial begin
        #10ms;
        $display("Timeout with %0d frames still due.", frames_due.size());
        $display("tb_spi_dataflash_command_sequencer: done, errors");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Idle length for either side: mostly none or short, a few long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    task automatic push_frame(input logic [7:0] mosi, input logic rel, input logic want,
                              input logic [7:0] rb, input logic rv, input logic done);
        t_spi_frame f;
        f.mosi_byte      = mosi;
        f.release_select = rel;
        f.want_reply     = want;
        f.read_byte      = rb;
        f.read_valid     = rv;
        f.done_res       = done;
        f.last           = 1'b0;
        frames_due.push_back(f);
    endtask

    // Main memory page address, reduced to the page count and packed for the
    // current page size.
    task automatic push_page(input logic [11:0] page);
        logic [11:0] pg;
        pg = 12'(page % PAGE_COUNT);
        if (pack_512) begin
            push_frame({3'b000, pg[11:7]}, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
            push_frame({pg[6:0], 1'b0}, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        end else begin
            push_frame({2'b00, pg[11:6]}, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
            push_frame({pg[5:0], 2'b00}, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        end
        push_frame(BYTE_ZERO, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic push_poll();
        push_frame(OPC_STATUS, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        push_frame(BYTE_ZERO, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
        seq_phase = SEQ_POLL;
    endtask

    // Works out the frames one accepted item causes and queues them.
    task automatic predict_frames(input logic [3:0] op, input logic buf_sel,
                                  input logic [11:0] page, input logic [9:0] offs,
                                  input logic [7:0] wdata, input logic wait_rdy,
                                  input logic [7:0] reply);
        int first;
        first = frames_due.size();
        if (op == OP_REPLY) begin
            case (seq_phase)
                SEQ_POLL: begin
                    if (reply[7]) begin
                        push_frame(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
                        seq_phase = SEQ_IDLE;
                    end else begin
                        push_poll();
                    end
                end
                SEQ_STATUS, SEQ_READ: begin
                    push_frame(8'h00, 1'b0, 1'b0, reply, 1'b1, 1'b1);
                    seq_phase = SEQ_IDLE;
                end
                SEQ_ID: begin
                    if (id_bytes_taken < 2'd2) begin
                        push_frame(BYTE_ONES, 1'b0, 1'b1, reply, 1'b1, 1'b0);
                        id_bytes_taken++;
                    end else begin
                        push_frame(BYTE_ONES, 1'b1, 1'b0, reply, 1'b1, 1'b1);
                        id_bytes_taken = '0;
                        seq_phase = SEQ_IDLE;
                    end
                end
                default: ;
            endcase
        end else if (seq_phase == SEQ_IDLE && op <= OP_ID) begin
            case (op)
                OP_PAGE_ERASE: begin
                    push_frame(OPC_PAGE_ERASE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_page(page);
                    push_poll();
                end
                OP_CHIP_ERASE: begin
                    push_frame(OPC_CHIP_ERASE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(OPC_CHIP_2, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(OPC_CHIP_3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(OPC_CHIP_4, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_poll();
                end
                OP_TO_BUF: begin
                    push_frame(buf_sel ? OPC_TO_BUF2 : OPC_TO_BUF1,
                               1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_page(page);
                    push_poll();
                end
                OP_TO_PAGE: begin
                    push_frame(buf_sel ? OPC_TO_PAGE2 : OPC_TO_PAGE1,
                               1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_page(page);
                    // Without a wait the command completes on its last address byte.
                    if (wait_rdy) push_poll();
                    else frames_due[$].done_res = 1'b1;
                end
                OP_WRITE: begin
                    push_frame(buf_sel ? OPC_WRITE2 : OPC_WRITE1,
                               1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(BYTE_ZERO, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame({6'b0, offs[9:8]}, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(offs[7:0], 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(wdata, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
                end
                OP_READ: begin
                    push_frame(buf_sel ? OPC_READ2 : OPC_READ1,
                               1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(BYTE_ZERO, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame({6'b0, offs[9:8]}, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(offs[7:0], 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(BYTE_ZERO, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(BYTE_ZERO, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
                    seq_phase = SEQ_READ;
                end
                OP_STATUS: begin
                    push_frame(OPC_STATUS, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(BYTE_ZERO, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
                    seq_phase = SEQ_STATUS;
                end
                default: begin
                    push_frame(OPC_ID, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
                    push_frame(BYTE_ONES, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
                    id_bytes_taken = '0;
                    seq_phase = SEQ_ID;
                end
            endcase
        end
        if (frames_due.size() > first) begin
            frames_due[$].last = 1'b1;
            items_acted++;
        end else begin
            items_ignored++;
        end
    endtask

    // Sends one item after a random gap; tvalid stays high for a following item.
    task automatic send_item(input logic [3:0] op, input logic buf_sel,
                             input logic [11:0] page, input logic [9:0] offs,
                             input logic [7:0] wdata, input logic wait_rdy,
                             input logic [7:0] reply);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {reply, wait_rdy, wdata, offs, page, buf_sel};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frames(op, buf_sel, page, offs, wdata, wait_rdy, reply);
    endtask

    task automatic send_cmd(input logic [3:0] op, input logic buf_sel,
                            input logic [11:0] page, input logic [9:0] offs,
                            input logic [7:0] wdata, input logic wait_rdy);
        send_item(op, buf_sel, page, offs, wdata, wait_rdy, 8'($urandom));
    endtask

    task automatic send_reply(input logic [7:0] reply);
        send_item(OP_REPLY, 1'($urandom), 12'($urandom), 10'($urandom),
                  8'($urandom), 1'($urandom), reply);
    endtask

    // Stops input and waits until the block has emptied out.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer; the bus is left idle afterwards.
    task automatic apb_access(input logic is_write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_PAGE_SIZE;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sets the page size register and reads it back.
    task automatic set_page_size(input logic is_512);
        logic [31:0] rdata;
        apb_access(1'b1, {31'b0, is_512}, rdata);
        pack_512 = is_512;
        apb_access(1'b0, 32'h0, rdata);
        if (rdata !== {31'b0, is_512})
            report_error($sformatf("page size read back %h, wrote %0d", rdata, is_512));
    endtask

    // Output side: random stalls, and each result checked against the oldest due.
    always @(posedge i_clk) begin
        t_spi_frame got;
        t_spi_frame due;
        int stall;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mosi_byte      = m_axis_tdata[7:0];
            got.release_select = m_axis_tdata[8];
            got.want_reply     = m_axis_tdata[9];
            got.read_byte      = m_axis_tdata[17:10];
            got.read_valid     = m_axis_tdata[18];
            got.done_res       = m_axis_tdata[19];
            got.last           = m_axis_tlast;
            if (frames_due.size() == 0) begin
                report_error($sformatf("frame %h with nothing due", m_axis_tdata));
            end else begin
                due = frames_due.pop_front();
                frames_checked++;
                if (got.mosi_byte !== due.mosi_byte
                        || got.release_select !== due.release_select
                        || got.want_reply !== due.want_reply
                        || got.read_byte !== due.read_byte
                        || got.read_valid !== due.read_valid
                        || got.done_res !== due.done_res
                        || got.last !== due.last)
                    report_error($sformatf(
                        "mosi/rel/want/rb/rv/done/last got %h/%b/%b/%h/%b/%b/%b due %h/%b/%b/%h/%b/%b/%b",
                        got.mosi_byte, got.release_select, got.want_reply, got.read_byte,
                        got.read_valid, got.done_res, got.last,
                        due.mosi_byte, due.release_select, due.want_reply, due.read_byte,
                        due.read_valid, due.done_res, due.last));
            end
        end
        stall = idle_gap();
        m_axis_tready <= (stall == 0) || ($urandom_range(0, 3) == 0);
    end

    // Register reset value and a write/read round trip.
    task automatic test_register_access();
        logic [31:0] rdata;
        apb_access(1'b0, 32'h0, rdata);
        if (rdata !== 32'h0)
            report_error($sformatf("page size reset value %h", rdata));
        set_page_size(1'b1);
        set_page_size(1'b0);
    endtask

    // Every command with field extremes, using 528-byte page packing.
    task automatic test_commands_528();
        // Page erase, polled once not ready and then ready.
        send_cmd(OP_PAGE_ERASE, 1'b0, 12'hFFF, 10'h3FF, 8'hFF, 1'b1);
        send_reply(8'h00);
        send_reply(8'h80);
        // Chip erase with its fixed four bytes.
        send_cmd(OP_CHIP_ERASE, 1'b1, 12'h000, 10'h000, 8'h00, 1'b0);
        send_reply(8'hFF);
        send_cmd(OP_TO_BUF, 1'b0, 12'h000, 10'h155, 8'h5A, 1'b0);
        send_reply(8'h80);
        send_cmd(OP_TO_BUF, 1'b1, 12'hFFF, 10'h2AA, 8'hA5, 1'b1);
        send_reply(8'hC3);
        // Buffer to page without waiting, then with a wait and a command while busy.
        send_cmd(OP_TO_PAGE, 1'b1, 12'hFFF, 10'h3FF, 8'hFF, 1'b0);
        send_cmd(OP_TO_PAGE, 1'b0, 12'hAAA, 10'h000, 8'h00, 1'b1);
        send_reply(8'h7F);
        send_cmd(OP_WRITE, 1'b1, 12'h555, 10'h3FF, 8'hFF, 1'b0);
        send_reply(8'h80);
        send_cmd(OP_WRITE, 1'b1, 12'h555, 10'h3FF, 8'hFF, 1'b1);
        send_cmd(OP_WRITE, 1'b0, 12'h000, 10'h000, 8'h00, 1'b0);
        send_cmd(OP_READ, 1'b1, 12'hFFF, 10'h3FF, 8'h00, 1'b0);
        send_reply(8'hA5);
        send_cmd(OP_READ, 1'b0, 12'h000, 10'h100, 8'h00, 1'b0);
        send_reply(8'h00);
        send_cmd(OP_STATUS, 1'b0, 12'h000, 10'h000, 8'h00, 1'b0);
        send_reply(8'h5A);
        // ID read takes three replies.
        send_cmd(OP_ID, 1'b0, 12'h000, 10'h000, 8'h00, 1'b0);
        send_reply(8'h1F);
        send_reply(8'h26);
        send_reply(8'hFF);
        // Items the block drops: a reply while idle and undefined ops.
        send_reply(8'h80);
        send_cmd(4'd9, 1'b1, 12'hFFF, 10'h3FF, 8'hFF, 1'b1);
        send_cmd(4'd15, 1'b1, 12'hFFF, 10'h3FF, 8'hFF, 1'b1);
        settle_idle();
    endtask

    // Page address packing for 512-byte pages.
    task automatic test_packing_512();
        set_page_size(1'b1);
        send_cmd(OP_PAGE_ERASE, 1'b1, 12'hFFF, 10'h000, 8'h00, 1'b0);
        send_reply(8'h80);
        send_cmd(OP_TO_PAGE, 1'b0, 12'h555, 10'h000, 8'h00, 1'b0);
        send_cmd(OP_TO_BUF, 1'b1, 12'hAAA, 10'h000, 8'h00, 1'b0);
        send_reply(8'hFF);
        settle_idle();
    endtask

    // Mostly well-formed command and reply sequences with random content,
    // some noise, and page size changes between stretches.
    task automatic test_random_traffic();
        int sent;
        logic [3:0] op;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ((sent % 60) == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ((sent % 115) == 114 && seq_phase == SEQ_IDLE) begin
                settle_idle();
                set_page_size(1'($urandom));
            end
            if ($urandom_range(0, 99) < 85)
                op = (seq_phase == SEQ_IDLE) ? 4'($urandom_range(0, 7)) : OP_REPLY;
            else if (seq_phase == SEQ_IDLE)
                op = 4'($urandom_range(8, 15));
            else
                op = 4'($urandom_range(0, 15));
            send_item(op, 1'($urandom), 12'($urandom), 10'($urandom), 8'($urandom),
                      1'($urandom), 8'($urandom));
            sent++;
        end
        calm = 1'b0;
        settle_idle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_commands_528();
        test_packing_512();
        test_random_traffic();
        $display("Sent %0d acted-on items and %0d dropped items, checked %0d frames,",
                 items_acted, items_ignored, frames_checked);
        $display("covering all commands, replies and both page address packings.");
        if (error_count == 0) begin
            $display("tb_spi_dataflash_command_sequencer: done, clean");
        end else begin
            $display("tb_spi_dataflash_command_sequencer: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/sdfcs_pkg.sv
src/sdfcs_front.sv
src/sdfcs_queue.sv
src/sdfcs_back.sv
src/spi_dataflash_command_sequencer.sv
sim/tb_spi_dataflash_command_sequencer.sv
